FILE: rtl/prc_pkg.sv
// Package for the paged record cache: shared constants, codes and types.
// Used by prc_ctrl, prc_dp and paged_record_cache_lru_top; depends on nothing.
`timescale 1ns / 1ps

package prc_pkg;

  // Cache geometry.
  localparam int MAX_SLOTS    = 8;
  localparam int SLOT_W       = 3;
  localparam int SLOT_RECORDS = 64;
  localparam int REC_W        = 6;
  localparam int MEM_DEPTH    = MAX_SLOTS * SLOT_RECORDS;
  localparam int MEM_AW       = SLOT_W + REC_W;
  // A record is eight bytes long, so the byte offset is a shift by three.
  localparam int RECORD_SHIFT = 3;

  // Configuration port.
  localparam int CFG_AW = 4;

  typedef enum logic [1:0] {
    REG_RPP   = 2'd0,
    REG_PAGES = 2'd1,
    REG_TOTAL = 2'd2,
    REG_BASE  = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    OP_LOOKUP = 3'd0,
    OP_PROBE  = 3'd1,
    OP_FILL   = 3'd2,
    OP_FAIL   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_HIT        = 3'd0,
    ST_MISS       = 3'd1,
    ST_RANGE      = 3'd2,
    ST_NOT_CACHED = 3'd3,
    ST_FILL       = 3'd4,
    ST_FAILED     = 3'd5,
    ST_CLEARED    = 3'd6,
    ST_REJECT     = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MISS,
    S_COMMIT,
    S_FILL_RD,
    S_EMIT
  } state_e;

  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_HIT,
    SRC_VICTIM,
    SRC_PEND
  } slot_src_e;

  typedef enum logic [1:0] {
    ACT_EMIT,
    ACT_HIT,
    ACT_MISS,
    ACT_FILL_LAST
  } act_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] index;
    logic [31:0] fill_time;
    logic [7:0]  fill_number;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  slot;
    logic [31:0] beat_time;
    logic [2:0]  beat_number;
    logic [31:0] fetch_first;
    logic [6:0]  fetch_count;
    logic [31:0] fetch_offset;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      capture;
    logic      do_hit;
    logic      miss_start;
    logic      miss_step;
    logic      commit;
    logic      fill_write;
    logic      fill_finish;
    logic      fill_read;
    logic      fail;
    logic      clear;
    logic      emit;
    logic      beat;
    status_e   status;
    slot_src_e slot_src;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] op;
    logic       pending;
    logic       in_range;
    logic       hit;
    logic       fill_last;
    logic       div_last;
  } stat_t;

endpackage

FILE: rtl/prc_ctrl.sv
// Controller state machine of the paged record cache.
// Depends on prc_pkg; drives the command word of prc_dp.
`timescale 1ns / 1ps

module prc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  prc_pkg::stat_t stat,
  output logic           busy,
  output prc_pkg::cmd_t  cmd
);

  prc_pkg::state_e    state_r, state_nxt;
  prc_pkg::status_e   held_status_r;
  prc_pkg::slot_src_e held_src_r;

  prc_pkg::act_e      act;
  prc_pkg::status_e   dec_status;
  prc_pkg::slot_src_e dec_src;
  logic               dec_fill, dec_fail, dec_clear;

  assign busy = (state_r != prc_pkg::S_IDLE);

  // Decision on the captured word, shared by next state and outputs.
  always_comb begin
    act        = prc_pkg::ACT_EMIT;
    dec_status = prc_pkg::ST_REJECT;
    dec_src    = prc_pkg::SRC_NONE;
    dec_fill   = 1'b0;
    dec_fail   = 1'b0;
    dec_clear  = 1'b0;
    case (stat.op)
      prc_pkg::OP_LOOKUP, prc_pkg::OP_PROBE: begin
        if (stat.op == prc_pkg::OP_LOOKUP && stat.pending) begin
          dec_status = prc_pkg::ST_REJECT;
        end else if (!stat.in_range) begin
          dec_status = prc_pkg::ST_RANGE;
        end else if (stat.hit) begin
          act = prc_pkg::ACT_HIT;
        end else if (stat.op == prc_pkg::OP_PROBE) begin
          dec_status = prc_pkg::ST_NOT_CACHED;
        end else begin
          act = prc_pkg::ACT_MISS;
        end
      end
      prc_pkg::OP_FILL: begin
        if (stat.pending) begin
          dec_fill = 1'b1;
          if (stat.fill_last) begin
            act = prc_pkg::ACT_FILL_LAST;
          end else begin
            dec_status = prc_pkg::ST_FILL;
            dec_src    = prc_pkg::SRC_PEND;
          end
        end
      end
      prc_pkg::OP_FAIL: begin
        if (stat.pending) begin
          dec_fail   = 1'b1;
          dec_status = prc_pkg::ST_FAILED;
          dec_src    = prc_pkg::SRC_PEND;
        end
      end
      prc_pkg::OP_CLEAR: begin
        dec_clear  = 1'b1;
        dec_status = prc_pkg::ST_CLEARED;
      end
      default: begin
        dec_status = prc_pkg::ST_REJECT;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      prc_pkg::S_IDLE: begin
        if (start) state_nxt = prc_pkg::S_DECODE;
      end
      prc_pkg::S_DECODE: begin
        case (act)
          prc_pkg::ACT_HIT:       state_nxt = prc_pkg::S_EMIT;
          prc_pkg::ACT_MISS:      state_nxt = prc_pkg::S_MISS;
          prc_pkg::ACT_FILL_LAST: state_nxt = prc_pkg::S_FILL_RD;
          default:                state_nxt = prc_pkg::S_IDLE;
        endcase
      end
      prc_pkg::S_MISS: begin
        if (stat.div_last) state_nxt = prc_pkg::S_COMMIT;
      end
      prc_pkg::S_COMMIT:  state_nxt = prc_pkg::S_IDLE;
      prc_pkg::S_FILL_RD: state_nxt = prc_pkg::S_EMIT;
      prc_pkg::S_EMIT:    state_nxt = prc_pkg::S_IDLE;
      default:            state_nxt = prc_pkg::S_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd = '0;
    case (state_r)
      prc_pkg::S_IDLE: begin
        cmd.capture = start;
      end
      prc_pkg::S_DECODE: begin
        cmd.fill_write = dec_fill;
        cmd.fail       = dec_fail;
        cmd.clear      = dec_clear;
        case (act)
          prc_pkg::ACT_HIT:       cmd.do_hit      = 1'b1;
          prc_pkg::ACT_MISS:      cmd.miss_start  = 1'b1;
          prc_pkg::ACT_FILL_LAST: cmd.fill_finish = 1'b1;
          default: begin
            cmd.emit     = 1'b1;
            cmd.status   = dec_status;
            cmd.slot_src = dec_src;
          end
        endcase
      end
      prc_pkg::S_MISS: begin
        cmd.miss_step = 1'b1;
      end
      prc_pkg::S_COMMIT: begin
        cmd.commit   = 1'b1;
        cmd.emit     = 1'b1;
        cmd.status   = prc_pkg::ST_MISS;
        cmd.slot_src = prc_pkg::SRC_VICTIM;
      end
      prc_pkg::S_FILL_RD: begin
        cmd.fill_read = 1'b1;
      end
      prc_pkg::S_EMIT: begin
        cmd.emit     = 1'b1;
        cmd.beat     = 1'b1;
        cmd.status   = held_status_r;
        cmd.slot_src = held_src_r;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // State register and the status held for a delayed word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= prc_pkg::S_IDLE;
      held_status_r <= prc_pkg::ST_HIT;
      held_src_r    <= prc_pkg::SRC_NONE;
    end else begin
      state_r <= state_nxt;
      if (state_r == prc_pkg::S_DECODE && act == prc_pkg::ACT_HIT) begin
        held_status_r <= prc_pkg::ST_HIT;
        held_src_r    <= prc_pkg::SRC_HIT;
      end else if (state_r == prc_pkg::S_DECODE && act == prc_pkg::ACT_FILL_LAST) begin
        held_status_r <= prc_pkg::ST_FILL;
        held_src_r    <= prc_pkg::SRC_PEND;
      end
    end
  end

endmodule

FILE: rtl/prc_dp.sv
// Datapath of the paged record cache: registers, slot tags, record memory,
// victim scan, page-alignment divider and result register. Depends on prc_pkg.
`timescale 1ns / 1ps

module prc_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [prc_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  input  prc_pkg::in_item_t          in_data,
  input  prc_pkg::cmd_t              cmd,
  output prc_pkg::stat_t             stat,
  output logic                       out_valid,
  output prc_pkg::out_item_t         out_data
);

  localparam int NS = prc_pkg::MAX_SLOTS;
  localparam int SW = prc_pkg::SLOT_W;
  localparam int RW = prc_pkg::REC_W;

  // Configuration registers.
  logic [6:0]  rpp_r;
  logic [3:0]  pages_r;
  logic [31:0] total_r;
  logic [31:0] base_r;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;
  logic        reopen;
  logic [6:0]  rpp_used;
  logic [3:0]  pages_used;

  // Captured word.
  logic [2:0]  op_r;
  logic [31:0] index_r;
  logic [31:0] ftime_r;
  logic [2:0]  num_r;
  logic [2:0]  num_clamp;

  // Slot tags.
  logic [NS-1:0] valid_r;
  logic [31:0]   stamp_r [NS];
  logic [31:0]   first_r [NS];
  logic [6:0]    count_r [NS];
  logic [31:0]   stamp_ctr_r;
  logic [31:0]   stamp_nxt;
  logic [31:0]   hit_ctr_r;
  logic [31:0]   miss_ctr_r;

  // Pending page load.
  logic          pending_r;
  logic [SW-1:0] pend_slot_r;
  logic [31:0]   pend_index_r;
  logic [31:0]   pend_first_r;
  logic [6:0]    pend_count_r;
  logic [6:0]    pos_r;
  logic [6:0]    pos_inc;

  // Hit search.
  logic [31:0]   diff [NS];
  logic [NS-1:0] hit_vec;
  logic [SW-1:0] hit_slot;
  logic [SW-1:0] hit_slot_r;
  logic [RW-1:0] hit_off;

  // Victim scan and divider.
  logic [SW-1:0] victim_r;
  logic          victim_valid_r;
  logic [31:0]   victim_stamp_r;
  logic [SW:0]   scan_i_r;
  logic [SW-1:0] scan_s;
  logic [6:0]    rem_r;
  logic [31:0]   div_sh_r;
  logic [4:0]    div_cnt_r;
  logic [7:0]    div_t;
  logic          div_ge;

  // Page fetch arithmetic.
  logic [31:0] fetch_first;
  logic [31:0] room;
  logic [6:0]  fetch_count;
  logic [31:0] fetch_offset;

  // Record memory: time and clamped number in one word.
  logic [34:0]               rec_mem [prc_pkg::MEM_DEPTH];
  logic [34:0]               rd_r;
  logic [prc_pkg::MEM_AW-1:0] mem_ra;
  logic [prc_pkg::MEM_AW-1:0] mem_wa;
  logic [RW-1:0]             fill_off;

  logic [SW-1:0] out_slot;

  // Configuration write decode and read-back.
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[3:2];
  assign reopen  = cfg_wr && (cfg_idx == prc_pkg::REG_TOTAL);

  always_comb begin
    case (cfg_idx)
      prc_pkg::REG_RPP:   prdata = {25'd0, rpp_r};
      prc_pkg::REG_PAGES: prdata = {28'd0, pages_r};
      prc_pkg::REG_TOTAL: prdata = total_r;
      prc_pkg::REG_BASE:  prdata = base_r;
      default:            prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rpp_r   <= 7'd64;
      pages_r <= 4'd8;
      total_r <= 32'd0;
      base_r  <= 32'd0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        prc_pkg::REG_RPP:   rpp_r   <= pwdata[6:0];
        prc_pkg::REG_PAGES: pages_r <= pwdata[3:0];
        prc_pkg::REG_TOTAL: total_r <= pwdata;
        prc_pkg::REG_BASE:  base_r  <= pwdata;
        default: ;
      endcase
    end
  end

  // Register values clamped to the ranges the cache supports.
  always_comb begin
    if (rpp_r == 7'd0) rpp_used = 7'd1;
    else if (rpp_r > 7'(prc_pkg::SLOT_RECORDS)) rpp_used = 7'(prc_pkg::SLOT_RECORDS);
    else rpp_used = rpp_r;
    if (pages_r == 4'd0) pages_used = 4'd1;
    else if (pages_r > 4'(NS)) pages_used = 4'(NS);
    else pages_used = pages_r;
  end

  // Capture of the input word.
  always_comb begin
    if (in_data.fill_number < 8'd1) num_clamp = 3'd1;
    else if (in_data.fill_number > 8'd4) num_clamp = 3'd4;
    else num_clamp = in_data.fill_number[2:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_data.op;
      index_r <= in_data.index;
      ftime_r <= in_data.fill_time;
      num_r   <= num_clamp;
    end
  end

  // Parallel hit check over the slots in use; the lowest slot wins.
  always_comb begin
    for (int s = 0; s < NS; s++) begin
      diff[s]    = index_r - first_r[s];
      hit_vec[s] = (4'(s) < pages_used) && valid_r[s] && (index_r >= first_r[s]) &&
                   (diff[s] < {25'd0, count_r[s]});
    end
    hit_slot = '0;
    for (int s = NS - 1; s >= 0; s--) begin
      if (hit_vec[s]) hit_slot = SW'(s);
    end
    hit_off = diff[hit_slot][RW-1:0];
  end

  assign stamp_nxt = stamp_ctr_r + 32'd1;
  assign pos_inc   = pos_r + 7'd1;

  assign stat.op        = op_r;
  assign stat.pending   = pending_r;
  assign stat.in_range  = (index_r < total_r);
  assign stat.hit       = |hit_vec;
  assign stat.fill_last = (pos_inc >= pend_count_r);
  assign stat.div_last  = (div_cnt_r == 5'd31);

  // Restoring remainder step: one index bit per cycle.
  assign div_t  = {rem_r, div_sh_r[31]};
  assign div_ge = (div_t >= {1'b0, rpp_used});
  assign scan_s = scan_i_r[SW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.miss_start) begin
      victim_r       <= '0;
      victim_valid_r <= valid_r[0];
      victim_stamp_r <= stamp_r[0];
      scan_i_r       <= (SW+1)'(1);
      rem_r          <= '0;
      div_sh_r       <= index_r;
      div_cnt_r      <= '0;
    end else if (cmd.miss_step) begin
      // Victim scan: last invalid slot, else first slot with least stamp.
      if (scan_i_r < pages_used) begin
        if (!valid_r[scan_s] || (victim_valid_r && stamp_r[scan_s] < victim_stamp_r)) begin
          victim_r       <= scan_s;
          victim_valid_r <= valid_r[scan_s];
          victim_stamp_r <= stamp_r[scan_s];
        end
        scan_i_r <= scan_i_r + (SW+1)'(1);
      end
      rem_r     <= div_ge ? 7'(div_t - {1'b0, rpp_used}) : div_t[6:0];
      div_sh_r  <= {div_sh_r[30:0], 1'b0};
      div_cnt_r <= div_cnt_r + 5'd1;
    end
  end

  // Fetch request of the page that holds the asked-for record.
  always_comb begin
    fetch_first  = index_r - {25'd0, rem_r};
    room         = total_r - fetch_first;
    fetch_count  = (room > {25'd0, rpp_used}) ? rpp_used : room[6:0];
    fetch_offset = base_r + {fetch_first[31-prc_pkg::RECORD_SHIFT:0],
                             {prc_pkg::RECORD_SHIFT{1'b0}}};
  end

  // Slot tags and counters that reset clears.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      stamp_ctr_r <= '0;
      hit_ctr_r   <= '0;
      miss_ctr_r  <= '0;
      pending_r   <= 1'b0;
      pend_slot_r <= '0;
      pend_index_r <= '0;
      pos_r       <= '0;
      for (int s = 0; s < NS; s++) stamp_r[s] <= '0;
    end else if (reopen) begin
      valid_r     <= '0;
      stamp_ctr_r <= '0;
      hit_ctr_r   <= '0;
      miss_ctr_r  <= '0;
      pending_r   <= 1'b0;
      pos_r       <= '0;
    end else begin
      if (cmd.do_hit) begin
        stamp_ctr_r       <= stamp_nxt;
        stamp_r[hit_slot] <= stamp_nxt;
        hit_ctr_r         <= hit_ctr_r + 32'd1;
      end
      if (cmd.commit) begin
        valid_r[victim_r] <= 1'b0;
        pending_r         <= 1'b1;
        pend_slot_r       <= victim_r;
        pend_index_r      <= index_r;
        pos_r             <= '0;
      end
      if (cmd.fill_write && !cmd.fill_finish) begin
        pos_r <= pos_inc;
      end
      if (cmd.fill_finish) begin
        stamp_ctr_r          <= stamp_nxt;
        stamp_r[pend_slot_r] <= stamp_nxt;
        valid_r[pend_slot_r] <= 1'b1;
        miss_ctr_r           <= miss_ctr_r + 32'd1;
        pending_r            <= 1'b0;
        pos_r                <= '0;
      end
      if (cmd.fail) begin
        valid_r[pend_slot_r] <= 1'b0;
        pending_r            <= 1'b0;
        pos_r                <= '0;
      end
      if (cmd.clear) begin
        valid_r   <= '0;
        pending_r <= 1'b0;
        pos_r     <= '0;
      end
    end
  end

  // Page bounds of each slot and of the pending load.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      first_r[victim_r] <= fetch_first;
      count_r[victim_r] <= fetch_count;
      pend_first_r      <= fetch_first;
      pend_count_r      <= fetch_count;
    end
    if (cmd.do_hit) begin
      hit_slot_r <= hit_slot;
    end
  end

  // Record memory: fills write, hits and completed loads read.
  assign fill_off = RW'(pend_index_r - pend_first_r);
  assign mem_wa   = {pend_slot_r, pos_r[RW-1:0]};
  assign mem_ra   = cmd.do_hit ? {hit_slot, hit_off} : {pend_slot_r, fill_off};

  always_ff @(posedge clk) begin
    if (cmd.fill_write) begin
      rec_mem[mem_wa] <= {ftime_r, num_r};
    end
    if (cmd.do_hit || cmd.fill_read) begin
      rd_r <= rec_mem[mem_ra];
    end
  end

  // Result register.
  always_comb begin
    case (cmd.slot_src)
      prc_pkg::SRC_HIT:    out_slot = hit_slot_r;
      prc_pkg::SRC_VICTIM: out_slot = victim_r;
      prc_pkg::SRC_PEND:   out_slot = pend_slot_r;
      default:             out_slot = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.status       <= cmd.status;
      out_data.slot         <= out_slot;
      out_data.beat_time    <= cmd.beat ? rd_r[34:3] : 32'd0;
      out_data.beat_number  <= cmd.beat ? rd_r[2:0] : 3'd0;
      out_data.hit_total    <= hit_ctr_r;
      out_data.miss_total   <= miss_ctr_r;
      if (cmd.status == prc_pkg::ST_MISS) begin
        out_data.fetch_first  <= fetch_first;
        out_data.fetch_count  <= fetch_count;
        out_data.fetch_offset <= fetch_offset;
      end else begin
        out_data.fetch_first  <= 32'd0;
        out_data.fetch_count  <= 7'd0;
        out_data.fetch_offset <= 32'd0;
      end
    end
  end

endmodule

FILE: rtl/paged_record_cache_lru_top.sv
// Top level of the paged record cache with LRU replacement.
// Depends on prc_pkg, prc_ctrl and prc_dp.
//
//   channel  | ports                                   | accepted when
//   ---------+-----------------------------------------+------------------------------
//   input    | start, busy, in_data                    | start high, busy low
//   result   | out_valid, out_data                     | every cycle out_valid is high
//   config   | psel, penable, pwrite, paddr, pwdata,   | psel, penable, pwrite, pready
//            | prdata, pready                          |
//
// One word is worked on at a time; busy stays high until its result is loaded.
// A hit and a completing fill read the record memory for their result; other words
// answer at decode; a miss waits on the one-bit-per-cycle page-alignment divider.
// The result strobe lasts one cycle and cannot be held off by the receiver.
// Reset is synchronous and active low; no clearing pass is needed after it.
`timescale 1ns / 1ps

module paged_record_cache_lru_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  prc_pkg::in_item_t          in_data,
  output logic                       out_valid,
  output prc_pkg::out_item_t         out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [prc_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  prc_pkg::cmd_t  cmd;
  prc_pkg::stat_t stat;

  assign pready = 1'b1;

  // Controller.
  prc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Datapath.
  prc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  // A result word only follows a cycle in which a word was being worked on.
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result word without a word in flight");

  // An accepted word makes the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // Each accepted word gets one result word; this checks that strobes never come back to back.
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");
`endif

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for paged_record_cache_lru_top: directed and random words
// are checked against an in-bench model of the page cache. Depends on prc_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;

  localparam logic [2:0] OP_UNKNOWN_FIRST = 3'd5;
  localparam logic [2:0] OP_UNKNOWN_LAST  = 3'd7;
  localparam int         CYCLE_LIMIT      = 400000;
  localparam int         SETTLE_CYCLES    = 40;

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  prc_pkg::in_item_t          in_data;
  logic                       out_valid;
  prc_pkg::out_item_t         out_data;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [prc_pkg::CFG_AW-1:0] paddr;
  logic [31:0]                pwdata;
  logic [31:0]                prdata;
  logic                       pready;

  paged_record_cache_lru_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Clock with a 12 ns period.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Model of the cache: configuration, page slots, record store and counters.
  logic [6:0]  cfg_rpp;
  logic [3:0]  cfg_pages;
  logic [31:0] cfg_total;
  logic [31:0] cfg_base;
  logic        pg_valid [prc_pkg::MAX_SLOTS];
  logic [31:0] pg_first [prc_pkg::MAX_SLOTS];
  logic [31:0] pg_count [prc_pkg::MAX_SLOTS];
  logic [31:0] pg_stamp [prc_pkg::MAX_SLOTS];
  logic [31:0] rec_time [prc_pkg::MEM_DEPTH];
  logic [2:0]  rec_num  [prc_pkg::MEM_DEPTH];
  logic [31:0] stamp_now;
  logic [31:0] hits;
  logic [31:0] loads;
  logic        loading;
  int          load_slot;
  logic [31:0] load_index;
  int          fill_pos;

  prc_pkg::out_item_t expected_words[$];
  int                 mismatches;
  int                 cycles;

  function automatic int used_rpp();
    if (cfg_rpp < 1) return 1;
    if (cfg_rpp > prc_pkg::SLOT_RECORDS) return prc_pkg::SLOT_RECORDS;
    return int'(cfg_rpp);
  endfunction

  function automatic int used_pages();
    if (cfg_pages < 1) return 1;
    if (cfg_pages > prc_pkg::MAX_SLOTS) return prc_pkg::MAX_SLOTS;
    return int'(cfg_pages);
  endfunction

  function automatic void drop_pages();
    for (int s = 0; s < prc_pkg::MAX_SLOTS; s++) pg_valid[s] = 1'b0;
    loading  = 1'b0;
    fill_pos = 0;
  endfunction

  function automatic void reset_model();
    cfg_rpp   = 7'd64;
    cfg_pages = 4'd8;
    cfg_total = '0;
    cfg_base  = '0;
    for (int s = 0; s < prc_pkg::MAX_SLOTS; s++) begin
      pg_valid[s] = 1'b0;
      pg_stamp[s] = '0;
    end
    stamp_now  = '0;
    hits       = '0;
    loads      = '0;
    loading    = 1'b0;
    load_slot  = 0;
    load_index = '0;
    fill_pos   = 0;
  endfunction

  // Places the record at index from slot s into the beat fields.
  function automatic void put_record(ref prc_pkg::out_item_t r, input int s,
                                     input logic [31:0] idx);
    logic [31:0] off;
    off = idx - pg_first[s];
    if (off < prc_pkg::SLOT_RECORDS) begin
      r.beat_time   = rec_time[s * prc_pkg::SLOT_RECORDS + off];
      r.beat_number = rec_num[s * prc_pkg::SLOT_RECORDS + off];
    end
  endfunction

  // Works out the result of one accepted word and advances the model.
  function automatic prc_pkg::out_item_t cache_result(prc_pkg::in_item_t w);
    prc_pkg::out_item_t r;
    int                 h;
    int                 victim;
    bit                 have;
    logic [31:0]        first;
    logic [31:0]        cnt;
    logic [2:0]         num;
    r = '0;
    r.status = prc_pkg::ST_REJECT;
    h = -1;
    if (w.op == prc_pkg::OP_LOOKUP || w.op == prc_pkg::OP_PROBE) begin
      if (w.op == prc_pkg::OP_LOOKUP && loading) begin
        r.status = prc_pkg::ST_REJECT;
      end else if (cfg_total == 0 || w.index >= cfg_total) begin
        r.status = prc_pkg::ST_RANGE;
      end else begin
        for (int s = used_pages() - 1; s >= 0; s--)
          if (pg_valid[s] && w.index >= pg_first[s] && w.index - pg_first[s] < pg_count[s])
            h = s;
        if (h >= 0) begin
          stamp_now++;
          pg_stamp[h] = stamp_now;
          hits++;
          r.status = prc_pkg::ST_HIT;
          r.slot   = 3'(h);
          put_record(r, h, w.index);
        end else if (w.op == prc_pkg::OP_PROBE) begin
          r.status = prc_pkg::ST_NOT_CACHED;
        end else begin
          // Victim: the last invalid slot, else the first with the least stamp.
          victim = 0;
          have   = 0;
          for (int s = 0; s < used_pages(); s++)
            if (!have || !pg_valid[s] ||
                (pg_valid[victim] && pg_stamp[s] < pg_stamp[victim])) begin
              victim = s;
              have   = 1;
            end
          first = w.index / 32'(used_rpp()) * 32'(used_rpp());
          cnt   = cfg_total - first;
          if (cnt > 32'(used_rpp())) cnt = 32'(used_rpp());
          pg_valid[victim] = 1'b0;
          pg_first[victim] = first;
          pg_count[victim] = cnt;
          loading    = 1'b1;
          load_slot  = victim;
          load_index = w.index;
          fill_pos   = 0;
          r.status       = prc_pkg::ST_MISS;
          r.slot         = 3'(victim);
          r.fetch_first  = first;
          r.fetch_count  = cnt[6:0];
          r.fetch_offset = cfg_base + (first << prc_pkg::RECORD_SHIFT);
        end
      end
    end else if (w.op == prc_pkg::OP_FILL) begin
      if (loading) begin
        num = w.fill_number < 1 ? 3'd1 : (w.fill_number > 4 ? 3'd4 : w.fill_number[2:0]);
        if (fill_pos < prc_pkg::SLOT_RECORDS) begin
          rec_time[load_slot * prc_pkg::SLOT_RECORDS + fill_pos] = w.fill_time;
          rec_num[load_slot * prc_pkg::SLOT_RECORDS + fill_pos]  = num;
        end
        fill_pos++;
        r.status = prc_pkg::ST_FILL;
        r.slot   = 3'(load_slot);
        if (fill_pos >= pg_count[load_slot]) begin
          stamp_now++;
          pg_stamp[load_slot] = stamp_now;
          pg_valid[load_slot] = 1'b1;
          loads++;
          loading  = 1'b0;
          fill_pos = 0;
          put_record(r, load_slot, load_index);
        end
      end
    end else if (w.op == prc_pkg::OP_FAIL) begin
      if (loading) begin
        pg_valid[load_slot] = 1'b0;
        r.slot   = 3'(load_slot);
        loading  = 1'b0;
        fill_pos = 0;
        r.status = prc_pkg::ST_FAILED;
      end
    end else if (w.op == prc_pkg::OP_CLEAR) begin
      drop_pages();
      r.status = prc_pkg::ST_CLEARED;
    end
    r.hit_total  = hits;
    r.miss_total = loads;
    return r;
  endfunction

  // Random gap: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sends one word and records its expected result once it is accepted.
  task automatic send_word(input logic [2:0] op, input logic [31:0] idx,
                           input logic [31:0] t, input logic [7:0] n);
    prc_pkg::in_item_t w;
    bit                taken;
    int                gap;
    w.op          = op;
    w.index       = idx;
    w.fill_time   = t;
    w.fill_number = n;
    start   <= 1'b1;
    in_data <= w;
    taken = 0;
    while (!taken) begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end
    expected_words.push_back(cache_result(w));
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Delivers random records until the pending page is complete.
  task automatic finish_load();
    while (loading)
      send_word(prc_pkg::OP_FILL, $urandom, $urandom, 8'($urandom_range(0, 255)));
  endtask

  // Waits until every expected word has come and the block has settled.
  task automatic drain();
    start <= 1'b0;
    wait (expected_words.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write: setup phase, access phase, then idle.
  task automatic write_reg(input prc_pkg::cfg_reg_e r, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      prc_pkg::REG_RPP:   cfg_rpp = v[6:0];
      prc_pkg::REG_PAGES: cfg_pages = v[3:0];
      prc_pkg::REG_TOTAL: begin
        cfg_total = v;
        drop_pages();
        stamp_now = '0;
        hits      = '0;
        loads     = '0;
      end
      prc_pkg::REG_BASE:  cfg_base = v;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Reports a mismatching field; each result word is compared with the oldest expectation.
  task automatic report_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s: expected %h, got %h", name, e, a);
    end
  endtask

  always @(negedge clk) begin
    prc_pkg::out_item_t e;
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_data);
      end else begin
        e = expected_words.pop_front();
        report_field("status", 32'(e.status), 32'(out_data.status));
        report_field("slot", 32'(e.slot), 32'(out_data.slot));
        report_field("beat_time", e.beat_time, out_data.beat_time);
        report_field("beat_number", 32'(e.beat_number), 32'(out_data.beat_number));
        report_field("fetch_first", e.fetch_first, out_data.fetch_first);
        report_field("fetch_count", 32'(e.fetch_count), 32'(out_data.fetch_count));
        report_field("fetch_offset", e.fetch_offset, out_data.fetch_offset);
        report_field("hit_total", e.hit_total, out_data.hit_total);
        report_field("miss_total", e.miss_total, out_data.miss_total);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Special cases: closed data, misses, hits, probes, rejects, failed loads, clear.
  task automatic test_special_cases();
    send_word(prc_pkg::OP_LOOKUP, 32'd3, '0, '0);
    drain();
    write_reg(prc_pkg::REG_TOTAL, 32'd100);
    write_reg(prc_pkg::REG_RPP, 32'd16);
    write_reg(prc_pkg::REG_PAGES, 32'd2);
    write_reg(prc_pkg::REG_BASE, 32'hFFFF_FFF0);
    drain();
    send_word(prc_pkg::OP_FILL, 32'd0, 32'h1234, 8'd2);
    send_word(prc_pkg::OP_FAIL, '0, '0, '0);
    send_word(prc_pkg::OP_LOOKUP, 32'd5, '0, '0);
    send_word(prc_pkg::OP_LOOKUP, 32'd6, '0, '0);
    send_word(prc_pkg::OP_PROBE, 32'd5, '0, '0);
    send_word(prc_pkg::OP_FILL, '0, 32'hFFFF_FFFF, 8'd0);
    send_word(prc_pkg::OP_FILL, '0, 32'h0, 8'd255);
    send_word(prc_pkg::OP_FILL, '0, 32'hA5A5_5A5A, 8'd5);
    finish_load();
    send_word(prc_pkg::OP_LOOKUP, 32'd2, '0, '0);
    send_word(prc_pkg::OP_PROBE, 32'd40, '0, '0);
    send_word(prc_pkg::OP_LOOKUP, 32'd99, '0, '0);
    send_word(prc_pkg::OP_FAIL, '0, '0, '0);
    send_word(prc_pkg::OP_LOOKUP, 32'd99, '0, '0);
    finish_load();
    send_word(prc_pkg::OP_LOOKUP, 32'd50, '0, '0);
    finish_load();
    send_word(prc_pkg::OP_PROBE, 32'd97, '0, '0);
    send_word(prc_pkg::OP_LOOKUP, 32'd100, '0, '0);
    send_word(prc_pkg::OP_CLEAR, '0, '0, '0);
    send_word(prc_pkg::OP_PROBE, 32'd97, '0, '0);
    for (int op = OP_UNKNOWN_FIRST; op <= OP_UNKNOWN_LAST; op++)
      send_word(op[2:0], $urandom, $urandom, 8'($urandom_range(0, 255)));
    drain();
  endtask

  // Register extremes: out-of-range sizes, the largest data set, wrapping offsets.
  task automatic test_register_extremes();
    write_reg(prc_pkg::REG_RPP, 32'd0);
    write_reg(prc_pkg::REG_PAGES, 32'd0);
    write_reg(prc_pkg::REG_TOTAL, 32'hFFFF_FFFF);
    write_reg(prc_pkg::REG_BASE, 32'hFFFF_FFFF);
    drain();
    send_word(prc_pkg::OP_LOOKUP, 32'hFFFF_FFFE, '0, '0);
    finish_load();
    send_word(prc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, '0, '0);
    send_word(prc_pkg::OP_LOOKUP, 32'h0, '0, '0);
    finish_load();
    send_word(prc_pkg::OP_PROBE, 32'hFFFF_FFFE, '0, '0);
    send_word(prc_pkg::OP_PROBE, 32'h0, '0, '0);
    drain();
    write_reg(prc_pkg::REG_RPP, 32'd127);
    write_reg(prc_pkg::REG_PAGES, 32'd15);
    drain();
    send_word(prc_pkg::OP_LOOKUP, 32'hFFFF_FFFE, '0, '0);
    finish_load();
    send_word(prc_pkg::OP_LOOKUP, 32'hFFFF_FFC0, '0, '0);
    send_word(prc_pkg::OP_LOOKUP, 32'h8000_0001, '0, '0);
    finish_load();
    drain();
    write_reg(prc_pkg::REG_RPP, 32'd64);
    write_reg(prc_pkg::REG_PAGES, 32'd8);
    drain();
  endtask

  // One random phase: mostly lookups near a few hot pages, with noise; mostly fills while a load is pending.
  task automatic random_phase(input int words, input logic [31:0] hot_span);
    logic [31:0] hot [4];
    logic [31:0] idx;
    int          pick;
    for (int k = 0; k < 4; k++)
      hot[k] = (cfg_total > hot_span) ? $urandom_range(0, cfg_total - hot_span) : 32'd0;
    for (int i = 0; i < words; i++) begin
      idx  = hot[$urandom_range(0, 3)] + $urandom_range(0, hot_span - 1);
      pick = $urandom_range(0, 99);
      if (loading) begin
        if (pick < 80)
          send_word(prc_pkg::OP_FILL, $urandom, $urandom, 8'($urandom_range(0, 255)));
        else if (pick < 85)
          send_word(prc_pkg::OP_FAIL, $urandom, $urandom, 8'($urandom_range(0, 255)));
        else if (pick < 90) send_word(prc_pkg::OP_LOOKUP, idx, $urandom, '0);
        else if (pick < 96)
          send_word(prc_pkg::OP_PROBE, idx, '0, 8'($urandom_range(0, 255)));
        else if (pick < 98) send_word(prc_pkg::OP_CLEAR, $urandom, '0, '0);
        else send_word(3'($urandom_range(OP_UNKNOWN_FIRST, OP_UNKNOWN_LAST)), $urandom, '0, '0);
      end else begin
        if (pick < 62)      send_word(prc_pkg::OP_LOOKUP, idx, $urandom, '0);
        else if (pick < 78) send_word(prc_pkg::OP_PROBE, idx, '0, '0);
        else if (pick < 84) send_word(prc_pkg::OP_LOOKUP, $urandom, '0, '0);
        else if (pick < 88)
          send_word(prc_pkg::OP_FILL, $urandom, $urandom, 8'($urandom_range(0, 255)));
        else if (pick < 91) send_word(prc_pkg::OP_FAIL, $urandom, '0, '0);
        else if (pick < 94) send_word(prc_pkg::OP_CLEAR, '0, '0, '0);
        else if (pick < 97) send_word(prc_pkg::OP_PROBE, $urandom, '0, '0);
        else send_word(3'($urandom_range(OP_UNKNOWN_FIRST, OP_UNKNOWN_LAST)), $urandom, '0, '0);
      end
    end
    drain();
  endtask

  // Random traffic across several settings, most with small pages.
  task automatic test_random_traffic();
    for (int p = 0; p < 6; p++) begin
      write_reg(prc_pkg::REG_RPP, (p == 5) ? $urandom_range(16, 64) : $urandom_range(1, 8));
      write_reg(prc_pkg::REG_PAGES, $urandom_range(0, 15));
      write_reg(prc_pkg::REG_TOTAL, (p == 3) ? $urandom : $urandom_range(20, 200));
      write_reg(prc_pkg::REG_BASE, $urandom);
      drain();
      random_phase((p == 5) ? 30 : 45, 32'(3 * used_rpp()));
    end
  endtask

  initial begin
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    cycles  = 0;
    mismatches = 0;
    reset_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_special_cases();
    test_register_extremes();
    test_random_traffic();
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/prc_pkg.sv
rtl/prc_ctrl.sv
rtl/prc_dp.sv
rtl/paged_record_cache_lru_top.sv
dv/testbench.sv
